// ----- hw/rtl/modular_exponentiation_macros.svh -----
// assertion macros for the modular exponentiation block
`ifndef MODULAR_EXPONENTIATION_MACROS_SVH
`define MODULAR_EXPONENTIATION_MACROS_SVH

// checked only outside reset
`define MEXP_ASSERT(name, expr, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) else $error(msg);

// checked during reset too
`define MEXP_ASSERT_RST(name, expr, msg) \
    name: assert property (@(posedge i_clk) (expr)) else $error(msg);

`endif

// ----- hw/rtl/mexp_pkg.sv -----
// shared constants and types for the modular exponentiation block
package mexp_pkg;

    localparam int ValBits = 30;
    localparam int ExpInBits = 32;
    localparam int ExpBits = 32;
    localparam int ExpCntW = $clog2(ExpBits + 1);
    localparam int MulCntW = $clog2(ValBits + 1);
    localparam int InDataW = 64;
    localparam int OutDataW = 32;

    localparam logic [ValBits-1:0] PrimeMod = ValBits'(1000000007);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SQR,
        ST_MUL,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic               start;
        logic [ValBits-1:0] op_a;
        logic [ValBits-1:0] op_b;
    } t_mul_req;

    typedef struct packed {
        logic               done;
        logic [ValBits-1:0] prod;
    } t_mul_rsp;

endpackage

// ----- hw/rtl/modular_exponentiation.sv -----
// modular exponentiation top level: square and multiply modulo 1000000007
//
// channel  dir  tdata fields (low bit up)
// s        in   base[29:0], exponent[61:30], zero pad to 64
// m        out  power[29:0], zero pad to 32
//
// each modular multiply, squares included, runs in the bit-serial multiplier
// an item takes one square per bit after the leading one and one multiply per set bit among them
// an exponent of zero or one needs no multiply at all
// synchronous reset clears control only; one item is in work at a time
// a finished result waits in the output register while the next word is taken
module modular_exponentiation
    import mexp_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_s_tvalid,
    output logic                o_s_tready,
    input  logic [InDataW-1:0]  i_s_tdata,   // base, exponent
    output logic                o_m_tvalid,
    input  logic                i_m_tready,
    output logic [OutDataW-1:0] o_m_tdata    // power
);

    t_state r_state, n_state;

    logic [ValBits-1:0] r_base, n_base;
    logic [ExpBits-1:0] r_exp, n_exp;
    logic [ValBits-1:0] r_acc, n_acc;
    logic [ExpCntW-1:0] r_cnt, n_cnt;
    logic               r_seen, n_seen;
    logic [ValBits-1:0] r_out, n_out;
    logic               r_out_vld, n_out_vld;

    t_mul_req w_req;
    t_mul_rsp w_rsp;

    logic               w_in_acc;
    logic               w_out_free;
    logic               w_bit;
    logic [ValBits-1:0] w_base_in;
    logic [ValBits-1:0] w_base_red;
    logic [63:0]        w_exp_wide;

    assign w_in_acc   = i_s_tvalid && o_s_tready;
    assign w_out_free = !r_out_vld || i_m_tready;
    assign w_bit      = r_exp[ExpBits-1];
    assign w_base_in  = i_s_tdata[ValBits-1:0];
    assign w_base_red = (w_base_in >= PrimeMod) ? (w_base_in - PrimeMod) : w_base_in;
    assign w_exp_wide = {{(64 - ExpInBits){1'b0}}, i_s_tdata[ValBits +: ExpInBits]};

    mexp_mulmod u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_rsp   (w_rsp)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_in_acc) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (r_cnt == '0) begin
                    n_state = ST_DONE;
                end else if (r_seen) begin
                    n_state = ST_SQR;
                end
            end
            ST_SQR: begin
                if (w_rsp.done) begin
                    n_state = w_bit ? ST_MUL : ST_SCAN;
                end
            end
            ST_MUL: begin
                if (w_rsp.done) begin
                    n_state = ST_SCAN;
                end
            end
            ST_DONE: begin
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        n_base    = r_base;
        n_exp     = r_exp;
        n_acc     = r_acc;
        n_cnt     = r_cnt;
        n_seen    = r_seen;
        n_out     = r_out;
        n_out_vld = r_out_vld && !i_m_tready;
        w_req     = '0;
        o_s_tready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    n_base = w_base_red;
                    n_exp  = w_exp_wide[ExpBits-1:0];
                    n_acc  = ValBits'(1);
                    n_cnt  = ExpCntW'(ExpBits);
                    n_seen = 1'b0;
                end
            end
            ST_SCAN: begin
                if (r_cnt != '0) begin
                    if (r_seen) begin
                        w_req.start = 1'b1;
                        w_req.op_a  = r_acc;
                        w_req.op_b  = r_acc;
                    end else begin
                        // leading zeros leave the product at one
                        if (w_bit) begin
                            n_acc  = r_base;
                            n_seen = 1'b1;
                        end
                        n_exp = {r_exp[ExpBits-2:0], 1'b0};
                        n_cnt = r_cnt - 1'b1;
                    end
                end
            end
            ST_SQR: begin
                if (w_rsp.done) begin
                    n_acc = w_rsp.prod;
                    if (w_bit) begin
                        w_req.start = 1'b1;
                        w_req.op_a  = w_rsp.prod;
                        w_req.op_b  = r_base;
                    end else begin
                        n_exp = {r_exp[ExpBits-2:0], 1'b0};
                        n_cnt = r_cnt - 1'b1;
                    end
                end
            end
            ST_MUL: begin
                if (w_rsp.done) begin
                    n_acc = w_rsp.prod;
                    n_exp = {r_exp[ExpBits-2:0], 1'b0};
                    n_cnt = r_cnt - 1'b1;
                end
            end
            ST_DONE: begin
                if (w_out_free) begin
                    n_out     = r_acc;
                    n_out_vld = 1'b1;
                end
            end
            default: begin
                n_out_vld = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_cnt     <= '0;
            r_seen    <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_cnt     <= n_cnt;
            r_seen    <= n_seen;
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_base <= n_base;
        r_exp  <= n_exp;
        r_acc  <= n_acc;
        r_out  <= n_out;
    end

    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = {{(OutDataW - ValBits){1'b0}}, r_out};

endmodule

// ----- hw/rtl/mexp_mulmod.sv -----
// bit-serial modular multiplier, one multiplier bit per cycle, msb first
module mexp_mulmod
    import mexp_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_mul_req i_req,
    output t_mul_rsp o_rsp
);

    localparam int SumW = ValBits + 2;

    logic [ValBits-1:0] r_a, n_a;
    logic [ValBits-1:0] r_b, n_b;
    logic [ValBits-1:0] r_acc, n_acc;
    logic [MulCntW-1:0] r_cnt, n_cnt;
    logic               r_busy, n_busy;
    logic               r_done, n_done;

    logic [SumW-1:0] w_sum;
    logic [SumW-1:0] w_mod1;
    logic [SumW-1:0] w_mod2;
    logic [ValBits-1:0] w_red;

    // 2*acc + a stays below 3*mod, so at most two subtractions
    assign w_sum  = {1'b0, r_acc, 1'b0} + (r_b[ValBits-1] ? SumW'(r_a) : '0);
    assign w_mod1 = SumW'(PrimeMod);
    assign w_mod2 = {1'b0, PrimeMod, 1'b0};

    always_comb begin
        priority if (w_sum >= w_mod2) begin
            w_red = ValBits'(w_sum - w_mod2);
        end else if (w_sum >= w_mod1) begin
            w_red = ValBits'(w_sum - w_mod1);
        end else begin
            w_red = ValBits'(w_sum);
        end
    end

    always_comb begin
        n_a    = r_a;
        n_b    = r_b;
        n_acc  = r_acc;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        if (i_req.start) begin
            n_a    = i_req.op_a;
            n_b    = i_req.op_b;
            n_acc  = '0;
            n_cnt  = MulCntW'(ValBits);
            n_busy = 1'b1;
        end else if (r_busy) begin
            n_acc = w_red;
            n_b   = {r_b[ValBits-2:0], 1'b0};
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == MulCntW'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a   <= n_a;
        r_b   <= n_b;
        r_acc <= n_acc;
    end

    assign o_rsp.done = r_done;
    assign o_rsp.prod = r_acc;

endmodule

// ----- hw/rtl/mexp_checker.sv -----
// port-level checks for the modular exponentiation block
`include "modular_exponentiation_macros.svh"

module mexp_checker
    import mexp_pkg::*;
(
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_s_tvalid,
    input logic                o_s_tready,
    input logic                o_m_tvalid,
    input logic                i_m_tready,
    input logic [OutDataW-1:0] o_m_tdata
);

    `MEXP_ASSERT_RST(a_no_word_after_reset, !i_rst_n |=> !o_m_tvalid, "result word out of reset")
    `MEXP_ASSERT(a_power_reduced, o_m_tvalid |-> (o_m_tdata[ValBits-1:0] < PrimeMod), "power not reduced")
    `MEXP_ASSERT(a_pad_zero, o_m_tvalid |-> (o_m_tdata[OutDataW-1:ValBits] == '0), "pad bits set")
    `MEXP_ASSERT(a_one_in_flight, (i_s_tvalid && o_s_tready) |=> !o_s_tready, "second word taken during work")
    `MEXP_ASSERT(a_result_held, (o_m_tvalid && !i_m_tready) |=> o_m_tvalid, "result dropped while stalled")

endmodule

bind modular_exponentiation mexp_checker u_mexp_checker (.*);

// ----- tb/modular_exponentiation_test.sv -----
// testbench for the modular exponentiation block: directed and random words
`timescale 1ns / 100ps

module modular_exponentiation_test;
    import mexp_pkg::*;

    localparam int StallMax = 19;
    localparam int IdleLimit = 20000;
    localparam int SettleCycles = 2200;
    localparam int ReportMax = 10;
    localparam longint unsigned ModValue = 64'd1000000007;
    localparam logic [ValBits-1:0] BaseTop = '1;

    typedef struct {
        logic [ValBits-1:0]   base;
        logic [ExpInBits-1:0] exponent;
        logic [ValBits-1:0]   power;
    } t_power_case;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_s_tvalid;
    logic                o_s_tready;
    logic [InDataW-1:0]  i_s_tdata;   // base[29:0], exponent[61:30], zero pad
    logic                o_m_tvalid;
    logic                i_m_tready;
    logic [OutDataW-1:0] o_m_tdata;   // power[29:0], zero pad

    t_power_case pending_powers[$];
    int          fail_count;
    int          idle_cycles;
    bit          no_idle;

    modular_exponentiation dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic logic [ValBits-1:0] predict_power(input logic [ValBits-1:0] base,
                                                          input logic [ExpInBits-1:0] exponent);
        longint unsigned b;
        longint unsigned acc;
        b = 64'(base);
        if (b >= ModValue) begin
            b = b - ModValue;
        end
        acc = 1;
        for (int i = ExpBits - 1; i >= 0; i--) begin
            acc = (acc * acc) % ModValue;
            if (exponent[i]) begin
                acc = (acc * b) % ModValue;
            end
        end
        return acc[ValBits-1:0];
    endfunction

    function automatic int draw_gap();
        return no_idle ? 0 : $urandom_range(0, StallMax);
    endfunction

    task automatic send_operands(input logic [ValBits-1:0] base,
                                 input logic [ExpInBits-1:0] exponent);
        int          gap;
        t_power_case entry;
        gap = draw_gap();
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {2'b00, exponent, base};
        do @(posedge i_clk); while (!o_s_tready);
        entry.base     = base;
        entry.exponent = exponent;
        entry.power    = predict_power(base, exponent);
        pending_powers.insert(pending_powers.size(), entry);
    endtask

    // hold off the sender until every pending power has come back
    task automatic drain_results();
        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending_powers.size() != 0) @(posedge i_clk);
    endtask

    function automatic logic [ValBits-1:0] random_base();
        int pick;
        pick = $urandom_range(0, 15);
        if (pick == 0) begin
            return ValBits'($urandom_range(1000000007, 32'h3fffffff));
        end else if (pick == 1) begin
            return ValBits'($urandom_range(0, 3));
        end
        return ValBits'($urandom_range(0, 1000000006));
    endfunction

    task automatic test_exponent_zero();
        send_operands('0, '0);
        send_operands(ValBits'(1), '0);
        send_operands(PrimeMod - 1'b1, '0);
        send_operands(BaseTop, '0);
    endtask

    task automatic test_exponent_one();
        send_operands('0, ExpInBits'(1));
        send_operands(ValBits'(1), ExpInBits'(1));
        send_operands(PrimeMod - 1'b1, ExpInBits'(1));
        send_operands(PrimeMod, ExpInBits'(1));
        send_operands(BaseTop, ExpInBits'(1));
    endtask

    task automatic test_operand_extremes();
        send_operands('0, ExpInBits'(5));
        send_operands('0, '1);
        send_operands(ValBits'(1), '1);
        send_operands(PrimeMod - 1'b1, '1);
        send_operands(ValBits'(2), ExpInBits'(32'h8000_0000));
        send_operands(BaseTop, ExpInBits'(32'hffff_fffe));
        send_operands(PrimeMod, ExpInBits'(32'h5555_5555));
        send_operands(ValBits'(123456789), ExpInBits'(1000000006));
        send_operands(ValBits'(2), ExpInBits'(1000000005));
        send_operands(BaseTop, ExpInBits'(32'haaaa_aaaa));
    endtask

    task automatic test_random_short_exponents(input int count);
        logic [ExpInBits-1:0] exponent;
        int                   width;
        for (int n = 0; n < count; n++) begin
            if (n % 100 == 0) begin
                no_idle = 1'b1;
            end else if (n % 100 == 40) begin
                no_idle = 1'b0;
            end
            if ($urandom_range(0, 7) == 0) begin
                exponent = $urandom;
            end else begin
                width = $urandom_range(0, 12);
                exponent = $urandom & ((32'd1 << width) - 1);
            end
            send_operands(random_base(), exponent);
        end
        no_idle = 1'b0;
    endtask

    task automatic test_random_wide_exponents(input int count);
        for (int n = 0; n < count; n++) begin
            no_idle = (n % 60) < 15;
            send_operands(random_base(), $urandom);
        end
        no_idle = 1'b0;
    endtask

    // result side: random stalls, then compare with the oldest prediction
    initial begin
        int          stall;
        t_power_case entry;
        i_m_tready = 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            stall = draw_gap();
            if (stall > 0) begin
                i_m_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_m_tready <= 1'b1;
            do @(posedge i_clk); while (!o_m_tvalid);
            if (pending_powers.size() == 0) begin
                fail_count++;
                if (fail_count <= ReportMax) begin
                    $display("unexpected word: power %0d", o_m_tdata[ValBits-1:0]);
                end
            end else begin
                entry = pending_powers.pop_front();
                if (o_m_tdata[ValBits-1:0] !== entry.power) begin
                    fail_count++;
                    if (fail_count <= ReportMax) begin
                        $display("power mismatch: base %0d exponent %0d expected %0d got %0d",
                                 entry.base, entry.exponent, entry.power,
                                 o_m_tdata[ValBits-1:0]);
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready) || !i_rst_n) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IdleLimit) begin
            $display("end of test: mismatches");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        fail_count  = 0;
        idle_cycles = 0;
        no_idle     = 1'b0;
        i_rst_n     = 1'b0;
        i_s_tvalid  = 1'b0;
        i_s_tdata   = '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_exponent_zero();
        test_exponent_one();
        test_operand_extremes();
        drain_results();
        test_random_short_exponents(1200);
        drain_results();
        test_random_wide_exponents(330);
        drain_results();

        repeat (SettleCycles) @(posedge i_clk);
        if (pending_powers.size() != 0) begin
            fail_count++;
        end
        if (fail_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
